// ===== rtl/pff_pkg.sv =====
// ----------------------------------------------------------------------------
// pff_pkg
// Shared constants for the potential field force vector core: default word
// format, register map codes and register reset values in whole units.
// ----------------------------------------------------------------------------
`default_nettype none

package pff_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  localparam logic [REG_IDX_W-1:0] REG_ATTRACT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_YAW       = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_REPEL     = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_INFLUENCE = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_RADIUS    = REG_IDX_W'(4);

  // reset values in whole units; body radius resets to half a unit
  localparam int ATTRACT_UNITS   = 5;
  localparam int YAW_UNITS       = 5;
  localparam int REPEL_UNITS     = 8;
  localparam int INFLUENCE_UNITS = 6;

endpackage

`default_nettype wire

// ===== rtl/pff_delay.sv =====
// ----------------------------------------------------------------------------
// pff_delay
// Fixed-length shift line that keeps side data aligned with a datapath unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/pff_qmul.sv =====
// ----------------------------------------------------------------------------
// pff_qmul
// Two-stage fixed-point multiply: magnitude times coefficient, round to
// nearest at the binary point, clip to the signed word, apply the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_qmul #(
  parameter int W = pff_pkg::WORD_BITS_DEF,
  parameter int F = pff_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic [W:0]          mag,
  input  logic [W-2:0]        coef,
  input  logic                neg,
  input  logic                sat_in,
  output logic signed [W-1:0] res,
  output logic                sat
);

  localparam int PW = 2 * W;

  logic [PW-1:0] prod;
  logic          neg_q;
  logic          sat_q;
  logic [PW:0]   rnd;
  logic [PW:0]   shr;
  logic [W-1:0]  lim;
  logic          clip;
  logic [W-1:0]  mag_r;

  always_ff @(posedge clk) begin
    prod  <= PW'(mag) * PW'(coef);
    neg_q <= neg;
    sat_q <= sat_in;
  end

  always_comb begin
    rnd   = {1'b0, prod} + ((PW+1)'(1) << (F - 1));
    shr   = rnd >> F;
    lim   = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    clip  = shr > (PW+1)'(lim);
    mag_r = clip ? lim : shr[W-1:0];
  end

  always_ff @(posedge clk) begin
    res <= neg_q ? (W'(0) - mag_r) : mag_r;
    sat <= sat_q | clip;
  end

endmodule

`default_nettype wire

// ===== rtl/pff_sqrt.sv =====
// ----------------------------------------------------------------------------
// pff_sqrt
// Pipelined integer square root, one root bit per stage, W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_sqrt #(
  parameter int W = pff_pkg::WORD_BITS_DEF
) (
  input  logic           clk,
  input  logic [2*W-1:0] sum,
  output logic [W-1:0]   root
);

  logic [2*W:0] rem_q  [W];
  logic [W-1:0] root_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int I = W - 1 - k;
    logic [2*W:0] rem_in;
    logic [2*W:0] trial;
    logic [W-1:0] root_in;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, sum};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^i)^2 - r^2
    assign trial = ((2*W+1)'(root_in) << (I + 1)) + ((2*W+1)'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_q[k]  <= rem_in - trial;
        root_q[k] <= root_in | (W'(1) << I);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
    end
  end

  assign root = root_q[W-1];

endmodule

`default_nettype wire

// ===== rtl/pff_div.sv =====
// ----------------------------------------------------------------------------
// pff_div
// Two-lane pipelined reciprocal: round(2^(2F)/d) by restoring division, one
// quotient bit per stage, then a clip to the largest positive word.
// ----------------------------------------------------------------------------
`default_nettype none

module pff_div #(
  parameter int W = pff_pkg::WORD_BITS_DEF,
  parameter int F = pff_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic [W-1:0] da,
  input  logic [W-1:0] db,
  output logic [W-2:0] qa,
  output logic [W-2:0] qb,
  output logic         sa,
  output logic         sb
);

  localparam int NUM_HI = (2 * F > W - 1) ? 2 * F : W - 1;
  localparam int NB     = NUM_HI + 1;

  logic [W-1:0]  rem_q  [2][NB];
  logic [NB-1:0] quot_q [2][NB];
  logic [NB-1:0] num_q  [2][NB];
  logic [W-1:0]  div_q  [2][NB];
  logic [W-2:0]  q_out  [2];
  logic          s_out  [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [W-1:0] d_in;

    if (l == 0) begin : g_a
      assign d_in = da;
    end else begin : g_b
      assign d_in = db;
    end

    for (genvar k = 0; k < NB; k++) begin : g_stage
      logic [W-1:0]  rem_in;
      logic [NB-1:0] quot_in;
      logic [NB-1:0] num_in;
      logic [W-1:0]  div_in;
      logic [W:0]    trial;

      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign quot_in = '0;
        assign num_in  = (NB'(1) << (2 * F)) + NB'(d_in >> 1);
        assign div_in  = d_in;
      end else begin : g_next
        assign rem_in  = rem_q[l][k-1];
        assign quot_in = quot_q[l][k-1];
        assign num_in  = num_q[l][k-1];
        assign div_in  = div_q[l][k-1];
      end

      assign trial = {rem_in, num_in[NB-1-k]};

      always_ff @(posedge clk) begin
        num_q[l][k] <= num_in;
        div_q[l][k] <= div_in;
        if (trial >= {1'b0, div_in}) begin
          rem_q[l][k]  <= W'(trial - {1'b0, div_in});
          quot_q[l][k] <= quot_in | (NB'(1) << (NB - 1 - k));
        end else begin
          rem_q[l][k]  <= trial[W-1:0];
          quot_q[l][k] <= quot_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (quot_q[l][NB-1] > NB'({(W-1){1'b1}})) begin
        q_out[l] <= {(W-1){1'b1}};
        s_out[l] <= 1'b1;
      end else begin
        q_out[l] <= quot_q[l][NB-1][W-2:0];
        s_out[l] <= 1'b0;
      end
    end
  end

  assign qa = q_out[0];
  assign qb = q_out[1];
  assign sa = s_out[0];
  assign sb = s_out[1];

endmodule

`default_nettype wire

// ===== rtl/potential_field_force_vector_core.sv =====
// ----------------------------------------------------------------------------
// potential_field_force_vector_core
// Guidance force from an artificial potential field: goal attraction on
// x, y, z and yaw, minus obstacle repulsion when the obstacle is near.
//
// Usage: raise start for one cycle with the position, heading, goal and
// obstacle offset on the input ports; busy stays low, so a new transfer
// may enter every cycle. Each transfer produces one result, shown on the
// force ports for one cycle with done high. Results come out in order.
// The pipeline is set by the bit-per-stage square root and the bit-per-stage
// reciprocal divider over NB = max(2*FRAC_BITS, WORD_BITS-1) + 1 quotient bits,
// followed by a chain of four rounded multiplies; the default format is Q16.16.
// Throughput is one transfer per cycle.
// The receiver cannot stall; results are not held.
// Configuration registers sit on the APB port; the user must write them while
// the pipeline is empty, the block does not enforce it. Reset clears the
// pipeline valid bits and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module potential_field_force_vector_core #(
  parameter int WORD_BITS = pff_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = pff_pkg::FRAC_BITS_DEF,
  localparam int RW       = WORD_BITS - 1,
  localparam int DATA_W   = (RW > 32) ? 64 : 32,
  localparam int STR_LG   = (RW > 32) ? 3 : 2,
  localparam int ADDR_W   = pff_pkg::REG_IDX_W + STR_LG
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] pos_x,
  input  logic signed [WORD_BITS-1:0] pos_y,
  input  logic signed [WORD_BITS-1:0] pos_z,
  input  logic signed [WORD_BITS-1:0] heading,
  input  logic signed [WORD_BITS-1:0] goal_x,
  input  logic signed [WORD_BITS-1:0] goal_y,
  input  logic signed [WORD_BITS-1:0] goal_z,
  input  logic signed [WORD_BITS-1:0] goal_heading,
  input  logic signed [WORD_BITS-1:0] obst_dx,
  input  logic signed [WORD_BITS-1:0] obst_dy,
  input  logic signed [WORD_BITS-1:0] obst_dz,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] force_x,
  output logic signed [WORD_BITS-1:0] force_y,
  output logic signed [WORD_BITS-1:0] force_z,
  output logic signed [WORD_BITS-1:0] force_heading,
  output logic                        obstacle_active,
  output logic                        saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ADDR_W-1:0]           paddr,
  input  logic [DATA_W-1:0]           pwdata,
  output logic [DATA_W-1:0]           prdata,
  output logic                        pready
);

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int NUM_HI = (2 * F > W - 1) ? 2 * F : W - 1;
  localparam int NB     = NUM_HI + 1;
  localparam int T_D    = 4 + W;
  localparam int T_V    = 5 + W + NB;
  localparam int LAT    = 17 + W + NB;

  typedef struct packed {
    logic                active;
    logic                att_sat;
    logic [3:0][W-1:0]   att;
    logic [2:0][W-1:0]   obst;
  } side_t;

  // configuration
  logic [RW-1:0] attract_gain;
  logic [RW-1:0] yaw_gain;
  logic [RW-1:0] repel_gain;
  logic [RW-1:0] influence_distance;
  logic [RW-1:0] body_radius;
  logic [pff_pkg::REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[ADDR_W-1:STR_LG];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attract_gain       <= RW'(pff_pkg::ATTRACT_UNITS) << F;
      yaw_gain           <= RW'(pff_pkg::YAW_UNITS) << F;
      repel_gain         <= RW'(pff_pkg::REPEL_UNITS) << F;
      influence_distance <= RW'(pff_pkg::INFLUENCE_UNITS) << F;
      body_radius        <= RW'(1) << (F - 1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pff_pkg::REG_ATTRACT:   attract_gain       <= pwdata[RW-1:0];
        pff_pkg::REG_YAW:       yaw_gain           <= pwdata[RW-1:0];
        pff_pkg::REG_REPEL:     repel_gain         <= pwdata[RW-1:0];
        pff_pkg::REG_INFLUENCE: influence_distance <= pwdata[RW-1:0];
        pff_pkg::REG_RADIUS:    body_radius        <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pff_pkg::REG_ATTRACT:   prdata = DATA_W'(attract_gain);
      pff_pkg::REG_YAW:       prdata = DATA_W'(yaw_gain);
      pff_pkg::REG_REPEL:     prdata = DATA_W'(repel_gain);
      pff_pkg::REG_INFLUENCE: prdata = DATA_W'(influence_distance);
      pff_pkg::REG_RADIUS:    prdata = DATA_W'(body_radius);
      default:                prdata = '0;
    endcase
  end

  // valid bits
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];

  // stage A: errors and obstacle magnitudes
  logic [W:0]          a_err  [4];
  logic [2:0][W-1:0]   a_obst;
  logic [W-1:0]        a_omag [3];

  always_ff @(posedge clk) begin
    a_err[0]  <= {goal_x[W-1], goal_x} - {pos_x[W-1], pos_x};
    a_err[1]  <= {goal_y[W-1], goal_y} - {pos_y[W-1], pos_y};
    a_err[2]  <= {goal_z[W-1], goal_z} - {pos_z[W-1], pos_z};
    a_err[3]  <= {goal_heading[W-1], goal_heading} - {heading[W-1], heading};
    a_obst[0] <= obst_dx;
    a_obst[1] <= obst_dy;
    a_obst[2] <= obst_dz;
    a_omag[0] <= obst_dx[W-1] ? (W'(0) - obst_dx) : obst_dx;
    a_omag[1] <= obst_dy[W-1] ? (W'(0) - obst_dy) : obst_dy;
    a_omag[2] <= obst_dz[W-1] ? (W'(0) - obst_dz) : obst_dz;
  end

  // attraction
  logic signed [W-1:0] att [4];
  logic [3:0]          att_sat;

  for (genvar k = 0; k < 4; k++) begin : g_att
    logic [W:0]    mag;
    logic [RW-1:0] gain;
    assign mag  = a_err[k][W] ? ((W+1)'(0) - a_err[k]) : a_err[k];
    assign gain = (k == 3) ? yaw_gain : attract_gain;
    pff_qmul #(.W(W), .F(F)) u_mul (
      .clk    (clk),
      .mag    (mag),
      .coef   (gain),
      .neg    (a_err[k][W]),
      .sat_in (1'b0),
      .res    (att[k]),
      .sat    (att_sat[k])
    );
  end

  // range
  logic [2*W-1:0]    sq [3];
  logic [2*W-1:0]    s_sum;
  logic [2:0][W-1:0] obst3;
  logic [W-1:0]      root;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq[k] <= (2*W)'(a_omag[k]) * (2*W)'(a_omag[k]);
    end
    s_sum <= sq[0] + sq[1] + sq[2];
  end

  pff_delay #(.WIDTH(3 * W), .DEPTH(2)) u_dly_obst (
    .clk  (clk),
    .din  (a_obst),
    .dout (obst3)
  );

  pff_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .sum  (s_sum),
    .root (root)
  );

  side_t side1_in, side1_out;

  always_comb begin
    side1_in.active  = 1'b0;
    side1_in.att_sat = |att_sat;
    for (int k = 0; k < 4; k++) begin
      side1_in.att[k] = att[k];
    end
    side1_in.obst = obst3;
  end

  pff_delay #(.WIDTH($bits(side_t)), .DEPTH(W + 1)) u_dly_side1 (
    .clk  (clk),
    .din  (side1_in),
    .dout (side1_out)
  );

  // stage D: obstacle distance
  logic signed [W:0] d_raw;
  logic [W-1:0]      d_next;
  logic [W-1:0]      d_q;
  logic              d_active_q;

  always_comb begin
    d_raw  = $signed({1'b0, root}) - $signed({2'b0, body_radius});
    d_next = (d_raw <= 0) ? W'(1) : d_raw[W-1:0];
  end

  always_ff @(posedge clk) begin
    d_q        <= d_next;
    d_active_q <= d_next < {1'b0, influence_distance};
  end

  logic [W-2:0] qa, qb;
  logic         sa, sb;

  pff_div #(.W(W), .F(F)) u_div (
    .clk (clk),
    .da  (d_q),
    .db  ({1'b0, influence_distance}),
    .qa  (qa),
    .qb  (qb),
    .sa  (sa),
    .sb  (sb)
  );

  side_t side2_in, side2_out;

  always_comb begin
    side2_in        = side1_out;
    side2_in.active = d_active_q;
  end

  pff_delay #(.WIDTH($bits(side_t)), .DEPTH(NB + 1)) u_dly_side2 (
    .clk  (clk),
    .din  (side2_in),
    .dout (side2_out)
  );

  // stage E: reciprocal difference
  logic [W-2:0] e_diff;
  logic [W-2:0] e_invd;
  logic         e_sat;
  side_t        e_side;

  always_ff @(posedge clk) begin
    e_diff <= (qa > qb) ? (qa - qb) : '0;
    e_invd <= qa;
    e_sat  <= side2_out.active & (sa | sb);
    e_side <= side2_out;
  end

  // repulsive gain chain
  logic signed [W-1:0] g    [4];
  logic                g_sat[4];
  logic [W-2:0]        invd [4];

  assign invd[0] = e_invd;

  for (genvar k = 0; k < 4; k++) begin : g_chain
    logic [W:0]   mag;
    logic [W-2:0] coef;
    logic         sat_in;

    if (k == 0) begin : g_first
      assign mag    = {2'b0, repel_gain};
      assign coef   = e_diff;
      assign sat_in = e_sat;
    end else begin : g_next
      assign mag    = {2'b0, g[k-1][W-2:0]};
      assign coef   = invd[k];
      assign sat_in = g_sat[k-1];
    end

    if (k < 3) begin : g_inv
      pff_delay #(.WIDTH(W - 1), .DEPTH(2)) u_dly_inv (
        .clk  (clk),
        .din  (invd[k]),
        .dout (invd[k+1])
      );
    end

    pff_qmul #(.W(W), .F(F)) u_mul (
      .clk    (clk),
      .mag    (mag),
      .coef   (coef),
      .neg    (1'b0),
      .sat_in (sat_in),
      .res    (g[k]),
      .sat    (g_sat[k])
    );
  end

  side_t side3_out;

  pff_delay #(.WIDTH($bits(side_t)), .DEPTH(8)) u_dly_side3 (
    .clk  (clk),
    .din  (e_side),
    .dout (side3_out)
  );

  // repulsion per axis
  logic signed [W-1:0] rep [3];
  logic [2:0]          rep_sat;

  for (genvar k = 0; k < 3; k++) begin : g_rep
    logic [W:0] mag;
    logic       neg;
    assign neg = side3_out.obst[k][W-1];
    assign mag = neg ? ((W+1)'(0) - {1'b1, side3_out.obst[k]}) : {1'b0, side3_out.obst[k]};
    pff_qmul #(.W(W), .F(F)) u_mul (
      .clk    (clk),
      .mag    (mag),
      .coef   (g[3][W-2:0]),
      .neg    (neg),
      .sat_in ((k == 0) ? g_sat[3] : 1'b0),
      .res    (rep[k]),
      .sat    (rep_sat[k])
    );
  end

  side_t side4_out;

  pff_delay #(.WIDTH($bits(side_t)), .DEPTH(2)) u_dly_side4 (
    .clk  (clk),
    .din  (side3_out),
    .dout (side4_out)
  );

  // final sum and clip
  logic [W:0]   f_sum  [3];
  logic [W-1:0] f_val  [3];
  logic [2:0]   f_clip;
  logic         f_sat;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_sum[k] = {side4_out.att[k][W-1], side4_out.att[k]}
               - (side4_out.active ? {rep[k][W-1], rep[k]} : (W+1)'(0));
      f_clip[k] = f_sum[k][W] != f_sum[k][W-1];
      if (!f_clip[k]) begin
        f_val[k] = f_sum[k][W-1:0];
      end else if (f_sum[k][W]) begin
        f_val[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        f_val[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
    f_sat = side4_out.att_sat | (side4_out.active & (|rep_sat)) | (|f_clip);
  end

  always_ff @(posedge clk) begin
    force_x         <= f_val[0];
    force_y         <= f_val[1];
    force_z         <= f_val[2];
    force_heading   <= side4_out.att[3];
    obstacle_active <= side4_out.active;
    saturated       <= f_sat;
  end

  // checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("result strobe missing after fixed latency");

  a_dist_pos: assert property (@(posedge clk) disable iff (rst)
    vld[T_D-1] |-> d_q != '0)
    else $error("obstacle distance not clamped");

  a_recip_order: assert property (@(posedge clk) disable iff (rst)
    vld[T_V-1] && side2_out.active |-> qa >= qb)
    else $error("near obstacle reciprocal below influence reciprocal");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without transfer");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the potential field force vector core. A queue of
// pending transfers feeds a clocked driver with random idle bursts; a clocked
// monitor compares every result against a bit-exact fixed-point prediction
// of the attraction and repulsion forces. Register settings change between
// phases, only once the pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int WB      = 32;
  localparam int FB      = 16;
  localparam int LATENCY = 82;
  localparam int LIMIT   = 200000;
  localparam int IDX_W   = pff_pkg::REG_IDX_W;
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(pff_pkg::NUM_REGS);
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF;
  localparam logic [63:0] NEG_MAG = 64'h8000_0000;

  typedef logic signed [WB-1:0] word_t;

  typedef struct {
    word_t pos_x, pos_y, pos_z, heading;
    word_t goal_x, goal_y, goal_z, goal_heading;
    word_t obst_dx, obst_dy, obst_dz;
  } pose_t;

  typedef struct {
    word_t fx, fy, fz, fh;
    logic  active, sat;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, obstacle_active, saturated, pready;
  word_t pos_x = '0, pos_y = '0, pos_z = '0, heading = '0;
  word_t goal_x = '0, goal_y = '0, goal_z = '0, goal_heading = '0;
  word_t obst_dx = '0, obst_dy = '0, obst_dz = '0;
  word_t force_x, force_y, force_z, force_heading;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [IDX_W+1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  potential_field_force_vector_core i_dut (
    .clk, .rst, .start, .busy,
    .pos_x, .pos_y, .pos_z, .heading,
    .goal_x, .goal_y, .goal_z, .goal_heading,
    .obst_dx, .obst_dy, .obst_dz,
    .done, .force_x, .force_y, .force_z, .force_heading,
    .obstacle_active, .saturated,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #5 clk = ~clk;

  // register shadow
  logic [63:0] k_att, k_yaw, k_rep, d_infl, r_body;

  pose_t  pose_q[$];
  force_t force_q[$];
  pose_t  cur_pose;
  int     errors = 0;
  int     gap = 0;
  bit     taken = 0;
  bit     idle_en = 1;
  bit     quiet = 0;
  int     cycles = 0;

  function automatic logic [63:0] qmul_mag(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] lim, inout bit sat);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (FB - 1))) >> FB;
    if (p > {64'd0, lim}) begin
      sat = 1;
      return lim;
    end
    return p[63:0];
  endfunction

  function automatic longint qmul_sgn(longint a, logic [63:0] b, inout bit sat);
    bit neg;
    logic [63:0] mag, r;
    neg = a < 0;
    mag = neg ? 64'(-a) : 64'(a);
    r = qmul_mag(mag, b, neg ? NEG_MAG : POS_MAX, sat);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic [63:0] inv_fix(logic [63:0] x, inout bit sat);
    logic [63:0] q;
    q = ((64'd1 << (2 * FB)) + x / 2) / x;
    if (q > POS_MAX) begin
      sat = 1;
      return POS_MAX;
    end
    return q;
  endfunction

  function automatic longint clip_word(longint x, inout bit sat);
    if (x > longint'(POS_MAX)) begin
      sat = 1;
      return longint'(POS_MAX);
    end
    if (x < -longint'(NEG_MAG)) begin
      sat = 1;
      return -longint'(NEG_MAG);
    end
    return x;
  endfunction

  function automatic force_t predict_force(pose_t p);
    force_t r;
    bit sat;
    longint att[3], rep[3], off[3], d, f;
    logic [127:0] sq, c2;
    logic [63:0] len, c, inv_d, inv_m, diff, g, m;
    sat = 0;
    att[0] = qmul_sgn(longint'(p.goal_x) - longint'(p.pos_x), k_att, sat);
    att[1] = qmul_sgn(longint'(p.goal_y) - longint'(p.pos_y), k_att, sat);
    att[2] = qmul_sgn(longint'(p.goal_z) - longint'(p.pos_z), k_att, sat);
    f = qmul_sgn(longint'(p.goal_heading) - longint'(p.heading), k_yaw, sat);
    off[0] = p.obst_dx;
    off[1] = p.obst_dy;
    off[2] = p.obst_dz;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      m = off[i] < 0 ? 64'(-off[i]) : 64'(off[i]);
      sq += {64'd0, m} * {64'd0, m};
      rep[i] = 0;
    end
    len = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      c = len | (64'd1 << i);
      c2 = {64'd0, c} * {64'd0, c};
      if (c2 <= sq) len = c;
    end
    d = longint'(len) - longint'(r_body);
    if (d <= 0) d = 1;
    r.active = d < longint'(d_infl);
    if (r.active) begin
      inv_d = inv_fix(64'(d), sat);
      inv_m = inv_fix(d_infl, sat);
      diff = inv_d > inv_m ? inv_d - inv_m : 64'd0;
      g = qmul_mag(k_rep, diff, POS_MAX, sat);
      g = qmul_mag(g, inv_d, POS_MAX, sat);
      g = qmul_mag(g, inv_d, POS_MAX, sat);
      g = qmul_mag(g, inv_d, POS_MAX, sat);
      for (int i = 0; i < 3; i++) rep[i] = qmul_sgn(off[i], g, sat);
    end
    r.fx = word_t'(clip_word(att[0] - rep[0], sat));
    r.fy = word_t'(clip_word(att[1] - rep[1], sat));
    r.fz = word_t'(clip_word(att[2] - rep[2], sat));
    r.fh = word_t'(f);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_diff(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // driver
  always @(negedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (!rst) begin
      if (start && !taken) begin
        nxt = 1'b1;
      end else if (gap > 0) begin
        gap--;
      end else if (pose_q.size() > 0) begin
        cur_pose = pose_q.pop_front();
        pos_x <= cur_pose.pos_x;
        pos_y <= cur_pose.pos_y;
        pos_z <= cur_pose.pos_z;
        heading <= cur_pose.heading;
        goal_x <= cur_pose.goal_x;
        goal_y <= cur_pose.goal_y;
        goal_z <= cur_pose.goal_z;
        goal_heading <= cur_pose.goal_heading;
        obst_dx <= cur_pose.obst_dx;
        obst_dy <= cur_pose.obst_dy;
        obst_dz <= cur_pose.obst_dz;
        nxt = 1'b1;
        if ($urandom_range(0, 29) == 0) idle_en = !idle_en;
        if (idle_en && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
      end
    end
    start <= nxt;
  end

  // transfer acceptance and result monitor
  always @(posedge clk) begin
    force_t w;
    taken = start && !busy && !rst;
    if (taken) force_q.push_back(predict_force(cur_pose));
    if (!rst && done) begin
      if (force_q.size() == 0) begin
        report_diff("unexpected result", force_x, 32'd0);
      end else begin
        w = force_q.pop_front();
        if (force_x !== w.fx) report_diff("force_x", force_x, w.fx);
        if (force_y !== w.fy) report_diff("force_y", force_y, w.fy);
        if (force_z !== w.fz) report_diff("force_z", force_z, w.fz);
        if (force_heading !== w.fh) report_diff("force_heading", force_heading, w.fh);
        if (obstacle_active !== w.active)
          report_diff("obstacle_active", 32'(obstacle_active), 32'(w.active));
        if (saturated !== w.sat) report_diff("saturated", 32'(saturated), 32'(w.sat));
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic apb_write(logic [IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pff_pkg::REG_ATTRACT:   k_att = val & POS_MAX;
      pff_pkg::REG_YAW:       k_yaw = val & POS_MAX;
      pff_pkg::REG_REPEL:     k_rep = val & POS_MAX;
      pff_pkg::REG_INFLUENCE: d_infl = val & POS_MAX;
      pff_pkg::REG_RADIUS:    r_body = val & POS_MAX;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check(logic [IDX_W-1:0] idx, logic [63:0] want);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[30:0] !== want[30:0]) report_diff("register readback", prdata, want[31:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] y, logic [31:0] k,
                          logic [31:0] dm, logic [31:0] rb);
    apb_write(pff_pkg::REG_ATTRACT, a);
    apb_write(pff_pkg::REG_YAW, y);
    apb_write(pff_pkg::REG_REPEL, k);
    apb_write(pff_pkg::REG_INFLUENCE, dm);
    apb_write(pff_pkg::REG_RADIUS, rb);
    apb_write(REG_UNUSED, $urandom);
    apb_check(pff_pkg::REG_ATTRACT, k_att);
    apb_check(pff_pkg::REG_YAW, k_yaw);
    apb_check(pff_pkg::REG_REPEL, k_rep);
    apb_check(pff_pkg::REG_INFLUENCE, d_infl);
    apb_check(pff_pkg::REG_RADIUS, r_body);
  endtask

  task automatic drain();
    while (pose_q.size() > 0 || start || force_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic pose_t mk_pose(word_t px, word_t py, word_t pz, word_t ph,
                                    word_t gx, word_t gy, word_t gz, word_t gh,
                                    word_t ox, word_t oy, word_t oz);
    pose_t p;
    p.pos_x = px; p.pos_y = py; p.pos_z = pz; p.heading = ph;
    p.goal_x = gx; p.goal_y = gy; p.goal_z = gz; p.goal_heading = gh;
    p.obst_dx = ox; p.obst_dy = oy; p.obst_dz = oz;
    return p;
  endfunction

  function automatic word_t near_val(int unsigned span);
    return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    int unsigned reach;
    int unsigned mode;
    p = mk_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom);
    mode = $urandom_range(0, 3);
    reach = (d_infl + r_body > 64'd16_000_000) ? 16_000_000 : int'(d_infl + r_body + 1);
    if (mode != 0) begin
      p.pos_x = near_val(1 << 20); p.pos_y = near_val(1 << 20);
      p.pos_z = near_val(1 << 20); p.heading = near_val(1 << 18);
      p.goal_x = near_val(1 << 20); p.goal_y = near_val(1 << 20);
      p.goal_z = near_val(1 << 20); p.goal_heading = near_val(1 << 18);
    end
    if (mode == 1 || mode == 2) begin
      p.obst_dx = near_val(reach);
      p.obst_dy = near_val(mode == 2 ? 4 : reach);
      p.obst_dz = near_val(mode == 2 ? 4 : reach);
    end
    if (mode == 3) begin
      p.obst_dx = near_val(64);
      p.obst_dy = near_val(64);
      p.obst_dz = near_val(64);
    end
    return p;
  endfunction

  initial begin
    word_t mx, mn;
    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    k_att = 64'(pff_pkg::ATTRACT_UNITS) << FB;
    k_yaw = 64'(pff_pkg::YAW_UNITS) << FB;
    k_rep = 64'(pff_pkg::REPEL_UNITS) << FB;
    d_infl = 64'(pff_pkg::INFLUENCE_UNITS) << FB;
    r_body = 64'd1 << (FB - 1);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    apb_check(pff_pkg::REG_ATTRACT, k_att);
    apb_check(pff_pkg::REG_YAW, k_yaw);
    apb_check(pff_pkg::REG_REPEL, k_rep);
    apb_check(pff_pkg::REG_INFLUENCE, d_infl);
    apb_check(pff_pkg::REG_RADIUS, r_body);

    // directed transfers under reset settings
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pose_q.push_back(mk_pose(mn, mn, mn, mn, mx, mx, mx, mx, mx, mx, mx));
    pose_q.push_back(mk_pose(mx, mx, mx, mx, mn, mn, mn, mn, mn, mn, mn));
    pose_q.push_back(mk_pose(-1, 1, -1, 1, 1, -1, 1, -1, 1, 0, 0));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 32768, 0, 0));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 32769, 0));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 425984, 0, 0));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 425983, 0, 0));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, -425983));
    pose_q.push_back(mk_pose(65536, 0, 0, 0, 0, 65536, 0, 3, 65536, 65536, 65536));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, mn, mn, mn));
    pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, mx, mx, mx));
    pose_q.push_back(mk_pose(mn, 0, mx, 0, 0, mn, 0, mx, 40000, -40000, 1));
    pose_q.push_back(mk_pose(0, 0, 0, mn, 0, 0, 0, mx, -32768, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        1: set_regs(0, 0, 0, 0, 32'h7FFF_FFFF);
        2: set_regs(1, 1, 1, 1, 1);
        3: set_regs(32'hFFFF_FFFF, 65536, 32'h8000_0000, 65536, 32768);
        default: set_regs($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 21),
                          $urandom_range(0, 1 << 22), $urandom_range(1, 1 << 20),
                          $urandom_range(0, 1 << 17));
      endcase
      if (ph == 0) begin
        pose_q.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pose_q.push_back(mk_pose(mn, mn, mn, mn, mx, mx, mx, mx, 1, 0, 0));
      end
      quiet = (ph == 7);
      for (int n = 0; n < 80; n++) begin
        pose_q.push_back(rand_pose());
        if (n == 40) begin
          while (pose_q.size() > 0 || start || force_q.size() > 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
